// File: design/twtl_pkg.sv
package twtl_pkg;

   // Mode codes
   localparam logic [2:0] MODE_INIT       = 3'd0;
   localparam logic [2:0] MODE_RED        = 3'd1;
   localparam logic [2:0] MODE_GREEN      = 3'd2;
   localparam logic [2:0] MODE_YELLOW     = 3'd3;
   localparam logic [2:0] MODE_SET_RED    = 3'd4;
   localparam logic [2:0] MODE_SET_GREEN  = 3'd5;
   localparam logic [2:0] MODE_SET_YELLOW = 3'd6;
   localparam logic [2:0] MODE_MANUAL     = 3'd7;

   // Lamp colors
   localparam logic [1:0] COLOR_OFF    = 2'd0;
   localparam logic [1:0] COLOR_RED    = 2'd1;
   localparam logic [1:0] COLOR_GREEN  = 2'd2;
   localparam logic [1:0] COLOR_YELLOW = 2'd3;

   // Pedestrian state codes
   localparam logic [1:0] WALK_IDLE  = 2'd0;
   localparam logic [1:0] WALK_RED   = 2'd1;
   localparam logic [1:0] WALK_GREEN = 2'd2;

   // Mode report codes
   localparam logic [2:0] MRPT_NONE       = 3'd0;
   localparam logic [2:0] MRPT_SET_RED    = 3'd1;
   localparam logic [2:0] MRPT_SET_GREEN  = 3'd2;
   localparam logic [2:0] MRPT_SET_YELLOW = 3'd3;
   localparam logic [2:0] MRPT_MANUAL     = 3'd4;
   localparam logic [2:0] MRPT_AUTO_RED   = 3'd5;

   // Configuration register indexes
   localparam logic [1:0] CSR_RED_DEFAULT    = 2'd0;
   localparam logic [1:0] CSR_GREEN_DEFAULT  = 2'd1;
   localparam logic [1:0] CSR_YELLOW_DEFAULT = 2'd2;

   // Duration limits
   localparam logic [4:0] DUR_WRAP      = 5'd10;
   localparam logic [3:0] WALK_MIN_LEFT = 4'd3;

   localparam logic [3:0] RED_DEFAULT_RST    = 4'd5;
   localparam logic [3:0] GREEN_DEFAULT_RST  = 4'd3;
   localparam logic [3:0] YELLOW_DEFAULT_RST = 4'd2;

   typedef struct packed {
      logic [3:0] red;
      logic [3:0] green;
      logic [3:0] yellow;
   } defaults_type;

   typedef struct packed {
      logic       tick;
      logic       mode_press;
      logic       adjust_press;
      logic       manual_press;
      logic       walk_press;
   } item_type;

   typedef struct packed {
      logic [2:0] mode;
      logic [3:0] phase_count;
      logic [3:0] red_time;
      logic [3:0] green_time;
      logic [3:0] yellow_time;
      logic [2:0] manual_color;
      logic [1:0] head2_hold;
      logic [1:0] walk_state;
      logic       tick_pending;
      logic       mode_pending;
      logic       walk_pending;
   } state_type;

   typedef struct packed {
      logic [3:0] mode_report_value;
      logic [2:0] mode_report;
      logic [3:0] adjusted_value;
      logic       adjust_report;
      logic [1:0] tick_report;
      logic [3:0] countdown;
      logic [2:0] mode_now;
      logic [1:0] walk_color;
      logic [1:0] head2_color;
      logic [1:0] head1_color;
   } result_type;

endpackage

// File: design/twtl_step.sv
module twtl_step (
   input  twtl_pkg::state_type    state_cur,
   input  twtl_pkg::defaults_type defaults,
   input  twtl_pkg::item_type     item,
   output twtl_pkg::state_type    state_nxt,
   output twtl_pkg::result_type   result
);

   // Pedestrian may cross while cross traffic is held
   function automatic logic walk_allowed(input twtl_pkg::state_type s);
      walk_allowed = (s.mode == twtl_pkg::MODE_RED && s.phase_count >= twtl_pkg::WALK_MIN_LEFT) ||
                     s.mode == twtl_pkg::MODE_SET_RED ||
                     (s.mode == twtl_pkg::MODE_MANUAL &&
                      (s.manual_color == 3'd1 || s.manual_color == 3'd3));
   endfunction

   function automatic logic walk_must_stop(input twtl_pkg::state_type s);
      walk_must_stop = s.mode == twtl_pkg::MODE_GREEN || s.mode == twtl_pkg::MODE_SET_GREEN ||
                       (s.mode == twtl_pkg::MODE_MANUAL && s.manual_color == 3'd2);
   endfunction

   // Add one second to a duration, wrap back to one
   function automatic logic [3:0] bump(input logic [3:0] v);
      logic [4:0] sum;
      sum = {1'b0, v} + 5'd1;
      bump = (sum >= twtl_pkg::DUR_WRAP) ? 4'd1 : sum[3:0];
   endfunction

   twtl_pkg::state_type  s;
   twtl_pkg::result_type r;
   logic [2:0]           next_mode;

   always_comb begin
      s         = state_cur;
      r         = '0;
      next_mode = twtl_pkg::MODE_RED;

      // Latch the sticky requests
      s.tick_pending = s.tick_pending | item.tick;
      s.mode_pending = s.mode_pending | item.mode_press;
      s.walk_pending = s.walk_pending | item.walk_press;

      // First beat after reset: load durations, start auto red
      if (s.mode == twtl_pkg::MODE_INIT) begin
         s.red_time     = defaults.red;
         s.green_time   = defaults.green;
         s.yellow_time  = defaults.yellow;
         s.phase_count  = defaults.red;
         s.tick_pending = 1'b0;
         r.tick_report  = twtl_pkg::COLOR_RED;
         s.mode         = twtl_pkg::MODE_RED;
      end

      if (s.mode == twtl_pkg::MODE_RED || s.mode == twtl_pkg::MODE_GREEN ||
          s.mode == twtl_pkg::MODE_YELLOW) begin
         // Auto countdown
         r.head1_color = s.mode[1:0];
         if (s.mode == twtl_pkg::MODE_RED) begin
            s.head2_hold = (s.phase_count >= s.yellow_time) ? twtl_pkg::COLOR_GREEN
                                                            : twtl_pkg::COLOR_YELLOW;
         end else begin
            s.head2_hold = twtl_pkg::COLOR_RED;
         end
         if (s.tick_pending) begin
            s.tick_pending = 1'b0;
            if (s.phase_count != 4'd0) begin
               s.phase_count = s.phase_count - 4'd1;
            end
            if (s.phase_count == 4'd0) begin
               next_mode = (s.mode == twtl_pkg::MODE_YELLOW) ? twtl_pkg::MODE_RED
                                                             : s.mode + 3'd1;
               case (next_mode)
                  twtl_pkg::MODE_RED:   s.phase_count = s.red_time;
                  twtl_pkg::MODE_GREEN: s.phase_count = s.green_time;
                  default:              s.phase_count = s.yellow_time;
               endcase
               s.mode = next_mode;
            end
            r.tick_report = s.mode[1:0];
         end
         if (s.mode_pending) begin
            s.mode_pending      = 1'b0;
            s.mode              = twtl_pkg::MODE_SET_RED;
            r.mode_report       = twtl_pkg::MRPT_SET_RED;
            r.mode_report_value = s.red_time;
         end
      end else if (s.mode == twtl_pkg::MODE_SET_RED || s.mode == twtl_pkg::MODE_SET_GREEN ||
                   s.mode == twtl_pkg::MODE_SET_YELLOW) begin
         // Duration setting
         next_mode     = s.mode - 3'd3;
         r.head1_color = next_mode[1:0];
         if (item.adjust_press) begin
            r.adjust_report = 1'b1;
            case (s.mode)
               twtl_pkg::MODE_SET_RED: begin
                  s.red_time       = bump(s.red_time);
                  r.adjusted_value = s.red_time;
               end
               twtl_pkg::MODE_SET_GREEN: begin
                  s.green_time     = bump(s.green_time);
                  r.adjusted_value = s.green_time;
               end
               default: begin
                  s.yellow_time    = bump(s.yellow_time);
                  r.adjusted_value = s.yellow_time;
               end
            endcase
         end
         if (s.mode_pending) begin
            s.mode_pending = 1'b0;
            case (s.mode)
               twtl_pkg::MODE_SET_RED: begin
                  r.mode_report       = twtl_pkg::MRPT_SET_GREEN;
                  r.mode_report_value = s.green_time;
               end
               twtl_pkg::MODE_SET_GREEN: begin
                  r.mode_report       = twtl_pkg::MRPT_SET_YELLOW;
                  r.mode_report_value = s.yellow_time;
               end
               default: begin
                  r.mode_report       = twtl_pkg::MRPT_MANUAL;
                  r.mode_report_value = 4'd0;
               end
            endcase
            s.mode = s.mode + 3'd1;
         end
      end else begin
         // Manual stepping of head 1
         r.head1_color = s.manual_color[1:0];
         if (item.manual_press) begin
            s.manual_color = s.manual_color + 3'd1;
         end
         if (s.manual_color > 3'd3 || s.manual_color == 3'd0) begin
            s.manual_color = 3'd1;
         end else if (s.mode_pending) begin
            s.mode_pending      = 1'b0;
            s.mode              = twtl_pkg::MODE_RED;
            s.phase_count       = s.red_time;
            r.mode_report       = twtl_pkg::MRPT_AUTO_RED;
            r.mode_report_value = s.red_time;
         end
      end

      // Pedestrian signal, sees the updated mode and count
      case (s.walk_state)
         twtl_pkg::WALK_GREEN: begin
            r.walk_color = twtl_pkg::COLOR_GREEN;
            if (walk_must_stop(s)) begin
               s.walk_state = twtl_pkg::WALK_IDLE;
            end
         end
         twtl_pkg::WALK_RED: begin
            r.walk_color = twtl_pkg::COLOR_RED;
            if (walk_allowed(s)) begin
               s.walk_state = twtl_pkg::WALK_GREEN;
            end
         end
         default: begin
            r.walk_color = twtl_pkg::COLOR_OFF;
            s.walk_state = twtl_pkg::WALK_IDLE;
            if (s.walk_pending) begin
               s.walk_pending = 1'b0;
               s.walk_state   = walk_allowed(s) ? twtl_pkg::WALK_GREEN : twtl_pkg::WALK_RED;
            end
         end
      endcase

      r.head2_color = s.head2_hold;
      r.mode_now    = s.mode;
      r.countdown   = s.phase_count;

      state_nxt = s;
      result    = r;
   end

endmodule

// File: design/two_way_traffic_light_controller_top.sv
// Two-way traffic light controller with pedestrian request.
//
// Input stream (req_): one beat per step, carrying the one-second tick and
// the mode, adjust, manual and walk buttons. Output stream (rsp_): one beat
// per input beat with both head colors, the walk light, the mode, the
// countdown and the tick, adjust and mode reports.
// Configuration (csr_): red, green and yellow default durations, picked up
// on the first step after reset; indexes above the list are dropped.
//
// Latency: a result beat is valid the cycle after its input beat is taken.
// Throughput: one beat per cycle; the whole step is one pass of logic from
// the state registers into the state and output registers.
// The output register holds one result; while it is full and the receiver
// stalls, req_tready falls, and it rises again in the cycle the result is
// taken, so a new beat enters alongside the handoff.
// Reset clears the state to the initial mode, empties the output register
// and restores the default durations to 5, 3 and 2 seconds.
module two_way_traffic_light_controller_top (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: tick, mode_press, adjust_press, manual_press, walk_press, zero fill
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   // rsp_tdata: head1_color, head2_color, walk_color, mode_now, countdown,
   // tick_report, adjust_report, adjusted_value, mode_report,
   // mode_report_value, zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [3:0]  csr_wdata
);

   twtl_pkg::defaults_type defaults_ff;
   twtl_pkg::state_type    state_ff;
   twtl_pkg::state_type    state_in;
   twtl_pkg::result_type   result_ff;
   twtl_pkg::result_type   result_in;
   twtl_pkg::item_type     item;
   logic                   rsp_valid_ff;
   logic                   req_take;

   // Unpack the input beat
   assign item.tick         = req_tdata[0];
   assign item.mode_press   = req_tdata[1];
   assign item.adjust_press = req_tdata[2];
   assign item.manual_press = req_tdata[3];
   assign item.walk_press   = req_tdata[4];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_take   = req_tvalid && req_tready;

   twtl_step u_step (
      .state_cur (state_ff),
      .defaults  (defaults_ff),
      .item      (item),
      .state_nxt (state_in),
      .result    (result_in)
   );

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         defaults_ff.red    <= twtl_pkg::RED_DEFAULT_RST;
         defaults_ff.green  <= twtl_pkg::GREEN_DEFAULT_RST;
         defaults_ff.yellow <= twtl_pkg::YELLOW_DEFAULT_RST;
      end else if (csr_we) begin
         case (csr_index)
            twtl_pkg::CSR_RED_DEFAULT:    defaults_ff.red    <= csr_wdata;
            twtl_pkg::CSR_GREEN_DEFAULT:  defaults_ff.green  <= csr_wdata;
            twtl_pkg::CSR_YELLOW_DEFAULT: defaults_ff.yellow <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Advance the controller state on each accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode         <= twtl_pkg::MODE_INIT;
         state_ff.phase_count  <= 4'd0;
         state_ff.red_time     <= 4'd0;
         state_ff.green_time   <= 4'd0;
         state_ff.yellow_time  <= 4'd0;
         state_ff.manual_color <= {1'b0, twtl_pkg::COLOR_RED};
         state_ff.head2_hold   <= twtl_pkg::COLOR_OFF;
         state_ff.walk_state   <= twtl_pkg::WALK_IDLE;
         state_ff.tick_pending <= 1'b0;
         state_ff.mode_pending <= 1'b0;
         state_ff.walk_pending <= 1'b0;
      end else if (req_take) begin
         state_ff <= state_in;
      end
   end

   // Output register: load on accept, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, result_ff};

   // Once started the controller never returns to the initial mode
   assert property (@(posedge clock) disable iff (reset)
      state_ff.mode != twtl_pkg::MODE_INIT |=> state_ff.mode != twtl_pkg::MODE_INIT)
      else $error("controller fell back to initial mode");

   // Manual color always normalized to red, green or yellow
   assert property (@(posedge clock) disable iff (reset)
      state_ff.manual_color == 3'd1 || state_ff.manual_color == 3'd2 ||
      state_ff.manual_color == 3'd3)
      else $error("manual color out of range");

   // Pedestrian state never takes the unused code
   assert property (@(posedge clock) disable iff (reset)
      state_ff.walk_state != 2'd3)
      else $error("walk state took unused code");

   // Every accepted beat yields a result beat next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_take |=> rsp_valid_ff)
      else $error("accepted beat produced no result");

endmodule
